// ===== sv/transformed_bounding_rectangle_unit_assert.svh =====
// assertion helpers shared by the bounding rectangle unit
`ifndef TRANSFORMED_BOUNDING_RECTANGLE_UNIT_ASSERT_SVH
`define TRANSFORMED_BOUNDING_RECTANGLE_UNIT_ASSERT_SVH

// condition must hold at every clock out of reset
`define TBR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TBR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/tbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbr_pkg
// Types and constants shared by the bounding rectangle unit modules.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int COORD_W   = 32;
    localparam int EXTENT_W  = 31;
    localparam int Q_FRAC    = 16;
    localparam int PROD_W    = 2 * COORD_W - Q_FRAC;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_COEF_X_FROM_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_X_FROM_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_X_FROM_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_Z_FROM_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_Z_FROM_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COEF_Z_FROM_Z = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z      = 3'd7;

    localparam logic [COORD_W-1:0] COEF_ONE  = 32'h0001_0000;
    localparam logic [COORD_W-1:0] COEF_ZERO = 32'h0000_0000;
    localparam logic [EXTENT_W-1:0] EXTENT_MAX = 31'h7FFF_FFFF;

    // one row of the affine transform
    typedef struct packed {
        logic signed [COORD_W-1:0] coef_x;
        logic signed [COORD_W-1:0] coef_y;
        logic signed [COORD_W-1:0] coef_z;
        logic signed [COORD_W-1:0] offset;
    } tbr_row_t;

    // transformed point handed from front to back
    typedef struct packed {
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] tz;
        logic                      last;
    } tbr_point_t;

endpackage

// ===== sv/tbr_front.sv =====
// ----------------------------------------------------------------------------
// tbr_front
// Three stage transform pipeline: products, partial sums, final sum with
// saturation. Never stalls; the top level only admits beats it has room for.
// ----------------------------------------------------------------------------
module tbr_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    input  logic signed [tbr_pkg::COORD_W-1:0] vertex_x,
    input  logic signed [tbr_pkg::COORD_W-1:0] vertex_y,
    input  logic signed [tbr_pkg::COORD_W-1:0] vertex_z,
    input  logic                               last_vertex,
    input  tbr_pkg::tbr_row_t                  row_x,
    input  tbr_pkg::tbr_row_t                  row_z,
    output logic                               push,
    output tbr_pkg::tbr_point_t                point
);
    import tbr_pkg::*;

    localparam int SUM1_W = PROD_W + 1;
    localparam int SUM2_W = PROD_W + 2;

    logic signed [2*COORD_W-1:0] prod_xx, prod_xy, prod_xz;
    logic signed [2*COORD_W-1:0] prod_zx, prod_zy, prod_zz;

    logic [PROD_W-1:0]  pxx_reg, pxy_reg, pxz_reg, pzx_reg, pzy_reg, pzz_reg;
    logic [COORD_W-1:0] offx_p_reg, offz_p_reg;
    logic               last_p_reg, valid_p_reg;

    logic [SUM1_W-1:0]  ax_reg, bx_reg, az_reg, bz_reg;
    logic               last_s_reg, valid_s_reg;

    logic [SUM2_W-1:0]  sum_x, sum_z;
    logic [COORD_W-1:0] sat_x, sat_z;
    tbr_point_t         point_reg;
    logic               valid_t_reg;

    // full products, truncated by 16 bits is floor division
    assign prod_xx = row_x.coef_x * vertex_x;
    assign prod_xy = row_x.coef_y * vertex_y;
    assign prod_xz = row_x.coef_z * vertex_z;
    assign prod_zx = row_z.coef_x * vertex_x;
    assign prod_zy = row_z.coef_y * vertex_y;
    assign prod_zz = row_z.coef_z * vertex_z;

    // product stage
    always_ff @(posedge aclk) begin
        pxx_reg    <= prod_xx[2*COORD_W-1:Q_FRAC];
        pxy_reg    <= prod_xy[2*COORD_W-1:Q_FRAC];
        pxz_reg    <= prod_xz[2*COORD_W-1:Q_FRAC];
        pzx_reg    <= prod_zx[2*COORD_W-1:Q_FRAC];
        pzy_reg    <= prod_zy[2*COORD_W-1:Q_FRAC];
        pzz_reg    <= prod_zz[2*COORD_W-1:Q_FRAC];
        offx_p_reg <= row_x.offset;
        offz_p_reg <= row_z.offset;
        last_p_reg <= last_vertex;
    end

    // partial sum stage
    always_ff @(posedge aclk) begin
        ax_reg <= {pxx_reg[PROD_W-1], pxx_reg} + {pxy_reg[PROD_W-1], pxy_reg};
        bx_reg <= {pxz_reg[PROD_W-1], pxz_reg}
                + {{(SUM1_W-COORD_W){offx_p_reg[COORD_W-1]}}, offx_p_reg};
        az_reg <= {pzx_reg[PROD_W-1], pzx_reg} + {pzy_reg[PROD_W-1], pzy_reg};
        bz_reg <= {pzz_reg[PROD_W-1], pzz_reg}
                + {{(SUM1_W-COORD_W){offz_p_reg[COORD_W-1]}}, offz_p_reg};
        last_s_reg <= last_p_reg;
    end

    // final sum and saturation to 32 bits
    assign sum_x = {ax_reg[SUM1_W-1], ax_reg} + {bx_reg[SUM1_W-1], bx_reg};
    assign sum_z = {az_reg[SUM1_W-1], az_reg} + {bz_reg[SUM1_W-1], bz_reg};

    always_comb begin
        priority if (!sum_x[SUM2_W-1] && (|sum_x[SUM2_W-2:COORD_W-1])) begin
            sat_x = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (sum_x[SUM2_W-1] && !(&sum_x[SUM2_W-2:COORD_W-1])) begin
            sat_x = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_x = sum_x[COORD_W-1:0];
        end
        priority if (!sum_z[SUM2_W-1] && (|sum_z[SUM2_W-2:COORD_W-1])) begin
            sat_z = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (sum_z[SUM2_W-1] && !(&sum_z[SUM2_W-2:COORD_W-1])) begin
            sat_z = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_z = sum_z[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        point_reg.tx   <= sat_x;
        point_reg.tz   <= sat_z;
        point_reg.last <= last_s_reg;
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_p_reg <= 1'b0;
            valid_s_reg <= 1'b0;
            valid_t_reg <= 1'b0;
        end else begin
            valid_p_reg <= in_valid;
            valid_s_reg <= valid_p_reg;
            valid_t_reg <= valid_s_reg;
        end
    end

    assign push  = valid_t_reg;
    assign point = point_reg;

endmodule

// ===== sv/tbr_fifo.sv =====
// ----------------------------------------------------------------------------
// tbr_fifo
// Small queue of transformed points between the front and back halves.
// ----------------------------------------------------------------------------
module tbr_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   push,
    input  tbr_pkg::tbr_point_t                    push_point,
    input  logic                                   pop,
    output logic                                   head_valid,
    output tbr_pkg::tbr_point_t                    head_point,
    output logic [$clog2(DEPTH+1)-1:0]             count
);
    import tbr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbr_point_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_point;
        end
    end

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_point = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

// ===== sv/tbr_back.sv =====
// ----------------------------------------------------------------------------
// tbr_back
// Running bounds per run, a snapshot of the final bounds on the last beat,
// and the result register that computes center and extent from it.
// ----------------------------------------------------------------------------
module tbr_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    input  tbr_pkg::tbr_point_t                 head_point,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tbr_pkg::COORD_W-1:0]  m_center_x,
    output logic signed [tbr_pkg::COORD_W-1:0]  m_center_z,
    output logic [tbr_pkg::EXTENT_W-1:0]        m_extent_x,
    output logic [tbr_pkg::EXTENT_W-1:0]        m_extent_z
);
    import tbr_pkg::*;

    logic signed [COORD_W-1:0] low_x_reg, high_x_reg, low_z_reg, high_z_reg;
    logic signed [COORD_W-1:0] low_x_next, high_x_next, low_z_next, high_z_next;
    logic                      started_reg;

    logic signed [COORD_W-1:0] snap_lx_reg, snap_hx_reg, snap_lz_reg, snap_hz_reg;
    logic                      snap_valid_reg;
    logic                      snap_move;

    logic [COORD_W:0]          mid_x, mid_z, diff_x, diff_z;
    logic [EXTENT_W-1:0]       ext_x, ext_z;

    logic                      out_valid_reg;
    logic [COORD_W-1:0]        center_x_reg, center_z_reg;
    logic [EXTENT_W-1:0]       extent_x_reg, extent_z_reg;

    // handshake between snapshot and result register
    assign snap_move = snap_valid_reg && (!out_valid_reg || m_ready);
    assign pop       = head_valid && (!snap_valid_reg || snap_move);

    // bounds after taking the head point
    always_comb begin
        if (!started_reg) begin
            low_x_next  = head_point.tx;
            high_x_next = head_point.tx;
            low_z_next  = head_point.tz;
            high_z_next = head_point.tz;
        end else begin
            low_x_next  = (head_point.tx < low_x_reg)  ? head_point.tx : low_x_reg;
            high_x_next = (head_point.tx > high_x_reg) ? head_point.tx : high_x_reg;
            low_z_next  = (head_point.tz < low_z_reg)  ? head_point.tz : low_z_reg;
            high_z_next = (head_point.tz > high_z_reg) ? head_point.tz : high_z_reg;
        end
    end

    // running bounds and run flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_x_reg   <= '0;
            high_x_reg  <= '0;
            low_z_reg   <= '0;
            high_z_reg  <= '0;
            started_reg <= 1'b0;
        end else if (pop) begin
            low_x_reg   <= low_x_next;
            high_x_reg  <= high_x_next;
            low_z_reg   <= low_z_next;
            high_z_reg  <= high_z_next;
            started_reg <= !head_point.last;
        end
    end

    // snapshot of the closing bounds
    always_ff @(posedge aclk) begin
        if (pop && head_point.last) begin
            snap_lx_reg <= low_x_next;
            snap_hx_reg <= high_x_next;
            snap_lz_reg <= low_z_next;
            snap_hz_reg <= high_z_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (pop && head_point.last) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_move) begin
            snap_valid_reg <= 1'b0;
        end
    end

    // center as floor of half the sum, extent clamped to the positive range
    assign mid_x  = {snap_lx_reg[COORD_W-1], snap_lx_reg} + {snap_hx_reg[COORD_W-1], snap_hx_reg};
    assign mid_z  = {snap_lz_reg[COORD_W-1], snap_lz_reg} + {snap_hz_reg[COORD_W-1], snap_hz_reg};
    assign diff_x = {snap_hx_reg[COORD_W-1], snap_hx_reg} - {snap_lx_reg[COORD_W-1], snap_lx_reg};
    assign diff_z = {snap_hz_reg[COORD_W-1], snap_hz_reg} - {snap_lz_reg[COORD_W-1], snap_lz_reg};

    always_comb begin
        priority if (diff_x[COORD_W]) begin
            ext_x = '0;
        end else if (diff_x[COORD_W-1]) begin
            ext_x = EXTENT_MAX;
        end else begin
            ext_x = diff_x[EXTENT_W-1:0];
        end
        priority if (diff_z[COORD_W]) begin
            ext_z = '0;
        end else if (diff_z[COORD_W-1]) begin
            ext_z = EXTENT_MAX;
        end else begin
            ext_z = diff_z[EXTENT_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (snap_move) begin
            center_x_reg <= mid_x[COORD_W:1];
            center_z_reg <= mid_z[COORD_W:1];
            extent_x_reg <= ext_x;
            extent_z_reg <= ext_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (snap_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_center_x = center_x_reg;
    assign m_center_z = center_z_reg;
    assign m_extent_x = extent_x_reg;
    assign m_extent_z = extent_z_reg;

endmodule

// ===== sv/transformed_bounding_rectangle_unit.sv =====
// ----------------------------------------------------------------------------
// transformed_bounding_rectangle_unit
// Axis aligned bounding rectangle of a vertex stream after an affine map.
// ----------------------------------------------------------------------------
// Input channel s_*: one vertex per beat, Q16.16 x/y/z plus s_last_vertex.
// Output channel m_*: one rectangle per run, sent after the vertex flagged
// last: center floor((min+max)/2) and extent max-min clamped to 31 bits.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one of the eight transform
// registers per write; write them only while no run is in flight.
// Throughput: one vertex per cycle, sustained, as long as the credits for the
// transform pipeline and the queue before the bounds tracker do not run out.
// After the last vertex is accepted, its result passes the three transform
// stages, the queue, the closing snapshot and the result register to m_valid.
// The queue credit counter sets s_ready: FIFO_DEPTH beats may be in the
// transform pipeline and queue together; at least five keep full rate.
// When m_ready is low the finished result holds, one more closing snapshot
// waits behind it, and vertices keep filling the queue until credits run out.
// Reset: registers return to the identity transform, all runs are dropped,
// and both channels go idle.
// ----------------------------------------------------------------------------
module transformed_bounding_rectangle_unit #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [tbr_pkg::REG_IDX_W-1:0]         cfg_addr,
    input  logic [tbr_pkg::COORD_W-1:0]           cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tbr_pkg::COORD_W-1:0]    s_vertex_x,
    input  logic signed [tbr_pkg::COORD_W-1:0]    s_vertex_y,
    input  logic signed [tbr_pkg::COORD_W-1:0]    s_vertex_z,
    input  logic                                  s_last_vertex,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [tbr_pkg::COORD_W-1:0]    m_center_x,
    output logic signed [tbr_pkg::COORD_W-1:0]    m_center_z,
    output logic [tbr_pkg::EXTENT_W-1:0]          m_extent_x,
    output logic [tbr_pkg::EXTENT_W-1:0]          m_extent_z
);
    import tbr_pkg::*;

    `include "transformed_bounding_rectangle_unit_assert.svh"

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [COORD_W-1:0] cfg_reg [NUM_REGS];
    tbr_row_t           row_x, row_z;

    logic               s_accept;
    logic               push, pop, head_valid;
    tbr_point_t         push_point, head_point;
    logic [CNT_W-1:0]   fifo_count;
    logic [CNT_W-1:0]   occ_reg, occ_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_COEF_X_FROM_X] <= COEF_ONE;
            cfg_reg[REG_COEF_X_FROM_Y] <= COEF_ZERO;
            cfg_reg[REG_COEF_X_FROM_Z] <= COEF_ZERO;
            cfg_reg[REG_OFFSET_X]      <= COEF_ZERO;
            cfg_reg[REG_COEF_Z_FROM_X] <= COEF_ZERO;
            cfg_reg[REG_COEF_Z_FROM_Y] <= COEF_ZERO;
            cfg_reg[REG_COEF_Z_FROM_Z] <= COEF_ONE;
            cfg_reg[REG_OFFSET_Z]      <= COEF_ZERO;
        end else if (cfg_we) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign row_x.coef_x = cfg_reg[REG_COEF_X_FROM_X];
    assign row_x.coef_y = cfg_reg[REG_COEF_X_FROM_Y];
    assign row_x.coef_z = cfg_reg[REG_COEF_X_FROM_Z];
    assign row_x.offset = cfg_reg[REG_OFFSET_X];
    assign row_z.coef_x = cfg_reg[REG_COEF_Z_FROM_X];
    assign row_z.coef_y = cfg_reg[REG_COEF_Z_FROM_Y];
    assign row_z.coef_z = cfg_reg[REG_COEF_Z_FROM_Z];
    assign row_z.offset = cfg_reg[REG_OFFSET_Z];

    // credits cover beats in the transform pipeline and in the queue
    assign s_ready  = (occ_reg < CNT_W'(FIFO_DEPTH));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        occ_next = occ_reg;
        if (s_accept && !pop) begin
            occ_next = occ_reg + 1'b1;
        end else if (pop && !s_accept) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    tbr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_accept),
        .vertex_x    (s_vertex_x),
        .vertex_y    (s_vertex_y),
        .vertex_z    (s_vertex_z),
        .last_vertex (s_last_vertex),
        .row_x       (row_x),
        .row_z       (row_z),
        .push        (push),
        .point       (push_point)
    );

    tbr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_point (push_point),
        .pop        (pop),
        .head_valid (head_valid),
        .head_point (head_point),
        .count      (fifo_count)
    );

    tbr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_point (head_point),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_center_x (m_center_x),
        .m_center_z (m_center_z),
        .m_extent_x (m_extent_x),
        .m_extent_z (m_extent_z)
    );

    // credit and queue consistency
    `TBR_ASSERT_ALWAYS(a_occ_bound, occ_reg <= CNT_W'(FIFO_DEPTH), "credit count overflow")
    `TBR_ASSERT_ALWAYS(a_fifo_within_credit, fifo_count <= occ_reg, "queue holds uncredited beats")
    `TBR_ASSERT_IMPLIES(a_push_has_credit, push, occ_reg != '0, "push without a credit")

endmodule
